>>> design/piecewise_linear_section_map_top_defines.svh
// Assertion macros for the piecewise linear section map RTL.
// Used by files that carry concurrent assertions; relies on clk_i and rst_ni in scope.
`ifndef PIECEWISE_LINEAR_SECTION_MAP_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_SECTION_MAP_TOP_DEFINES_SVH

// same-cycle implication
`define PLSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/plsm_pkg.sv
// Shared types and constants for the piecewise linear section map.
// No dependencies; imported by every module of the block.
package plsm_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int DIV_STEPS    = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
  localparam int PADDR_W      = 3;

  localparam logic [31:0] NOT_FOUND_Q16 = 32'hFFFF_0000;  // -1.0
  localparam logic [3:0]  COUNT_RESET   = 4'd1;
  localparam logic [PADDR_W-3:0] REG_SECTION_COUNT = '0;   // word index

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MAP   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_INSIDE     = 2'd0,
    ST_CLAMP_LOW  = 2'd1,
    ST_CLAMP_HIGH = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } map_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_DONE
  } fsm_state_e;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         section_index;
    logic signed [31:0] in_low;
    logic signed [31:0] in_high;
    logic signed [31:0] out_low;
    logic signed [31:0] out_high;
    logic signed [31:0] position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mapped_value;
    logic [1:0]         map_status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] in_min;
    logic signed [31:0] in_max;
    logic signed [31:0] out_min;
    logic signed [31:0] out_max;
  } section_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    section_t         data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> design/plsm_table.sv
// Section table: synchronous memory, one write and one read port, registered read data.
// Depends on plsm_pkg.
module plsm_table (
  input  logic               clk_i,
  input  plsm_pkg::tbl_wr_t  wr_i,
  input  plsm_pkg::tbl_rd_t  rd_i,
  output plsm_pkg::section_t rd_data_o
);
  import plsm_pkg::*;

  section_t mem_q [MAX_SECTIONS];
  section_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/plsm_div.sv
// Restoring divider, one quotient bit per cycle, 64/32 with a 32-bit quotient.
// Caller guarantees dividend[63:32] < divisor. Depends on plsm_pkg.
module plsm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plsm_pkg::div_req_t  req_i,
  output plsm_pkg::div_stat_t stat_o,
  output logic [31:0]         quotient_o
);
  import plsm_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [31:0]          rem_q, rem_d;
  logic [31:0]          quo_q, quo_d;
  logic [31:0]          divisor_q;
  logic [32:0]          partial;
  logic [33:0]          trial;
  logic                 ge;

  assign partial = {rem_q, quo_q[31]};
  assign trial   = {1'b0, partial} - {2'b00, divisor_q};
  assign ge      = !trial[33];

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      cnt_d = DIV_CNT_W'(DIV_STEPS);
      rem_d = req_i.dividend[63:32];
      quo_d = req_i.dividend[31:0];
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
      rem_d  = ge ? trial[31:0] : partial[31:0];
      quo_d  = {quo_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      divisor_q <= req_i.divisor;
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

>>> design/piecewise_linear_section_map_top.sv
// Piecewise linear section map; one transaction in flight.
// A map scans the sections in use in S_CHECK; a clamp, not found or zero-width match then
// goes straight to S_DONE, while an interpolation passes through S_MUL, the serial divide in
// S_DIV and S_DONE. The input stalls meanwhile.
// Scan is idle again when out_valid_o rises; a held result delays the next finish only.
// Reset (async, active low): section_count = 1, scan idle, output empty; table undefined.
`include "piecewise_linear_section_map_top_defines.svh"

module piecewise_linear_section_map_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  plsm_pkg::in_item_t        in_item_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output plsm_pkg::out_item_t       out_item_o,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [plsm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import plsm_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register. Only section_count lives here; word index from
  // paddr[PADDR_W-1:2], byte lanes ignored.
  // ---------------------------------------------------------------------------
  logic [3:0] count_q;
  logic       cfg_wr;
  logic       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_SECTION_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? {28'd0, count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_wr) begin
      count_q <= pwdata[3:0];
    end
  end

  // Last scanned entry: a count of zero acts as one, a count past the table
  // saturates at the table depth.
  logic [IDX_W-1:0] last_w;
  always_comb begin
    if (count_q == 4'd0) begin
      last_w = '0;
    end else if (int'(count_q) > MAX_SECTIONS) begin
      last_w = IDX_W'(MAX_SECTIONS - 1);
    end else begin
      last_w = IDX_W'(count_q - 4'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Submodules: section memory and serial divider.
  // ---------------------------------------------------------------------------
  tbl_wr_t   tbl_wr;
  tbl_rd_t   tbl_rd;
  section_t  cur;
  div_req_t  div_req;
  div_stat_t div_stat;
  logic [31:0] quotient;

  plsm_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_i      (tbl_rd),
    .rd_data_o (cur)
  );

  plsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // ---------------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------------
  fsm_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, last_q;
  logic signed [31:0] pos_q;
  logic signed [31:0] e0_in_min_q, e0_out_min_q;
  logic [31:0] a_q, b_q, range_q;
  logic signed [31:0] omin_q;
  logic        neg_q;
  logic signed [31:0] res_value_q;
  map_status_e res_status_q;
  out_item_t   out_item_q;
  logic        out_valid_q;

  logic in_acc, out_free, is_map, is_last, hit, zero_w;
  logic signed [31:0] e0_in_min, e0_out_min;
  logic [31:0] range_w, a_w, b_w;
  logic [32:0] odiff, mid_sum, interp;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_map   = (in_item_i.opcode == OP_MAP);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = (idx_q == last_q);

  // entry 0 is the current read data on the first scan step
  assign e0_in_min  = (idx_q == '0) ? cur.in_min  : e0_in_min_q;
  assign e0_out_min = (idx_q == '0) ? cur.out_min : e0_out_min_q;

  // inclusive range test; a reversed section never matches
  assign hit     = ($signed(pos_q) >= $signed(cur.in_min)) &&
                   ($signed(pos_q) <= $signed(cur.in_max));
  assign range_w = cur.in_max - cur.in_min;
  assign zero_w  = (range_w == 32'd0);
  assign a_w     = pos_q - cur.in_min;
  assign odiff   = {cur.out_max[31], cur.out_max} - {cur.out_min[31], cur.out_min};
  assign b_w     = odiff[32] ? 32'(-odiff) : odiff[31:0];
  // zero-width section: floor((out_min + out_max) / 2)
  assign mid_sum = {cur.out_min[31], cur.out_min} + {cur.out_max[31], cur.out_max};

  // final step of an interpolation: out_min +/- quotient
  assign interp  = neg_q ? ({omin_q[31], omin_q} - {1'b0, quotient})
                         : ({omin_q[31], omin_q} + {1'b0, quotient});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && is_map) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit) begin
          state_d = zero_w ? S_DONE : S_MUL;
        end else if (is_last) begin
          state_d = S_DONE;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o       = 1'b1;
    tbl_wr.en        = 1'b0;
    tbl_wr.addr      = IDX_W'(in_item_i.section_index);
    tbl_wr.data      = '{in_min:  in_item_i.in_low,  in_max:  in_item_i.in_high,
                         out_min: in_item_i.out_low, out_max: in_item_i.out_high};
    tbl_rd.en        = 1'b0;
    tbl_rd.addr      = '0;
    div_req.start    = 1'b0;
    div_req.dividend = a_q * b_q;
    div_req.divisor  = range_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc && !is_map && (int'(in_item_i.section_index) < MAX_SECTIONS)) begin
          tbl_wr.en = 1'b1;
        end
        if (in_acc && is_map) begin
          tbl_rd.en = 1'b1;
        end
      end
      S_CHECK: begin
        if (!hit && !is_last) begin
          tbl_rd.en   = 1'b1;
          tbl_rd.addr = idx_q + IDX_W'(1);
        end
      end
      S_MUL:   div_req.start = 1'b1;
      S_DIV:   ;
      S_DONE:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        idx_q <= '0;
      end else if (state_q == S_CHECK && !hit && !is_last) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc && is_map) begin
      pos_q  <= in_item_i.position;
      last_q <= last_w;
    end
    if (state_q == S_CHECK) begin
      e0_in_min_q  <= e0_in_min;
      e0_out_min_q <= e0_out_min;
      if (hit) begin
        a_q     <= a_w;
        b_q     <= b_w;
        range_q <= range_w;
        omin_q  <= cur.out_min;
        neg_q   <= odiff[32];
        if (zero_w) begin
          res_value_q  <= mid_sum[32:1];
          res_status_q <= ST_INSIDE;
        end
      end else if (is_last) begin
        priority if ($signed(pos_q) < $signed(e0_in_min)) begin
          res_value_q  <= e0_out_min;
          res_status_q <= ST_CLAMP_LOW;
        end else if ($signed(pos_q) > $signed(cur.in_max)) begin
          res_value_q  <= cur.out_max;
          res_status_q <= ST_CLAMP_HIGH;
        end else begin
          res_value_q  <= NOT_FOUND_Q16;
          res_status_q <= ST_NOT_FOUND;
        end
      end
    end
    if (state_q == S_DIV && div_stat.done) begin
      res_value_q  <= interp[31:0];
      res_status_q <= ST_INSIDE;
    end
    if (state_q == S_DONE && out_free) begin
      out_item_q.mapped_value <= res_value_q;
      out_item_q.map_status   <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PLSM_ASSERT_NXT(a_map_enters_scan, in_acc && is_map, state_q == S_CHECK,
                   "map transaction did not start a scan")
  `PLSM_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == S_DIV,
                   "divider finished outside the divide state")
  `PLSM_ASSERT_IMP(a_scan_bound, state_q == S_CHECK, idx_q <= last_q,
                   "scan index ran past the last section in use")
  `PLSM_ASSERT_NXT(a_result_loaded, state_q == S_DONE && out_free, out_valid_o,
                   "finished result was not presented")

endmodule
